[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define MF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent on the next edge
`define MF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/mf2d_pkg.sv]
// ----------------------------------------------------------------------------
// mf2d_pkg
// shared types, sizes and border helpers of the 2-d median filter
// ----------------------------------------------------------------------------
package mf2d_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_WINDOW  = 5;
    localparam int NUM_CELLS   = MAX_WINDOW * MAX_WINDOW;
    localparam int MED_IDX_3   = 9 / 2;
    localparam int MED_IDX_5   = NUM_CELLS / 2;
    localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic clear;
        logic insert;
    } sort_ctrl_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] value;
    } cell_t;

    // reflect-101 for coordinates at most two outside the range
    function automatic logic [9:0] reflect101(input logic signed [11:0] j,
                                              input logic [10:0] n);
        logic signed [12:0] p;
        logic signed [12:0] t;
        logic signed [12:0] ns;
        ns = $signed({2'b00, n});
        p  = ns + ns - 13'sd2;
        t  = {j[11], j};
        if (t < 0)
            t = -t;
        if (t >= ns)
            t = p - t;
        if (t < 0)
            t = -t;
        if (n <= 11'd1)
            t = '0;
        return t[9:0];
    endfunction

endpackage

[rtl/median_filter_2d_reflect.sv]
// ----------------------------------------------------------------------------
// median_filter_2d_reflect
// streaming 3x3 / 5x5 median filter with reflect-101 borders
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall with req_type and pixel_value, pixels in
// raster order, then radius*width drain items to flush the last rows.
// output channel: out_valid/out_stall, up to three results per input item,
// last_of_run marks the final one, frame_done the frame's last pixel.
// config: cfg_we/cfg_index/cfg_data, written only while idle; a write to
// index 0..2 restarts the frame cursors, a write to index 3 does not.
// an item that gives no result leaves the block idle. each result gathers
// k*k samples from the single-port line store (k = 3 or 5), one per cycle,
// into the sorter cell chain, then passes a settle state and is shown in
// the output state, where it waits while out_stall is high.
// in_stall stays high while a result is built or waits on out_stall.
// reset clears cursors and registers (radius 1, 1024x1024); the line store
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module median_filter_2d_reflect
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [15:0] pixel_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] median_value,
    output logic [9:0]  out_col,
    output logic [9:0]  out_row,
    output logic        last_of_run,
    output logic        frame_done
);
    import mf2d_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [1:0] {ST_IDLE, ST_GATHER, ST_SETTLE, ST_OUT} state_t;

    state_t      state_reg, state_next;
    logic [1:0]  radius_reg, radius_next;
    logic [10:0] width_reg, width_next;
    logic [10:0] height_reg, height_next;
    logic [9:0]  in_col_reg, in_col_next;
    logic [10:0] in_row_reg, in_row_next;
    logic [2:0]  in_slot_reg, in_slot_next;
    logic [9:0]  col_reg, col_next;
    logic [9:0]  end_reg, end_next;
    logic [9:0]  orow_reg, orow_next;
    logic [2:0]  oslot_reg, oslot_next;
    logic [2:0]  ky_reg, ky_next;
    logic [2:0]  kx_reg, kx_next;
    logic        rd_v_reg, rd_v_next;

    logic [15:0] store [STORE_DEPTH];
    logic [15:0] mem_q;

    logic        big;
    logic [1:0]  rad;
    logic [2:0]  kmax;
    logic [10:0] w, h;
    logic        accept, drop, emit, wr_en, last_tap, gather;
    logic [10:0] x1, y1;
    logic [9:0]  start_c, end_c;
    logic [3:0]  os_tmp;
    logic signed [11:0] jrow, jcol, diff;
    logic [9:0]  sy, sx;
    logic signed [4:0] s_tmp;
    logic [2:0]  rd_slot;
    logic [12:0] rd_addr;
    logic [15:0] median;
    sort_ctrl_t  sctrl;

    always_comb
    begin
        big  = radius_reg[1];
        rad  = big ? 2'd2 : 2'd1;
        kmax = big ? 3'd4 : 3'd2;
        w = (width_reg == 11'd0) ? 11'd1 :
            (width_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_reg;
        h = (height_reg == 11'd0) ? 11'd1 :
            (height_reg > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : height_reg;

        accept = in_valid && !in_stall;
        drop   = req_type ? (in_row_reg < h) : (in_row_reg >= h);
        wr_en  = accept && !req_type && !drop;
        x1     = {1'b0, in_col_reg} + 11'd1;
        y1     = in_row_reg + 11'd1;
        emit   = !drop && (in_row_reg >= {9'd0, rad}) &&
                 ({1'b0, in_col_reg} >= {9'd0, rad} || x1 == w);
        start_c = ({1'b0, in_col_reg} >= {9'd0, rad}) ? in_col_reg - {8'd0, rad} : 10'd0;
        end_c   = (x1 == w) ? 10'(w - 11'd1) : in_col_reg - {8'd0, rad};
        os_tmp  = {1'b0, in_slot_reg} + 4'd5 - {2'd0, rad};
        if (os_tmp >= 4'd5)
            os_tmp = os_tmp - 4'd5;

        jrow = $signed({2'b00, orow_reg}) + $signed({9'd0, ky_reg}) - $signed({10'd0, rad});
        jcol = $signed({2'b00, col_reg}) + $signed({9'd0, kx_reg}) - $signed({10'd0, rad});
        sy   = reflect101(jrow, h);
        sx   = reflect101(jcol, w);
        diff = $signed({2'b00, sy}) - $signed({2'b00, orow_reg});
        s_tmp = $signed({2'b00, oslot_reg}) + diff[4:0];
        if (s_tmp < 0)
            s_tmp = s_tmp + 5'sd5;
        else if (s_tmp >= 5'sd5)
            s_tmp = s_tmp - 5'sd5;
        rd_slot  = s_tmp[2:0];
        rd_addr  = {rd_slot, sx};
        gather   = (state_reg == ST_GATHER);
        last_tap = (ky_reg == kmax) && (kx_reg == kmax);

        sctrl.clear  = (state_reg == ST_IDLE) ||
                       (state_reg == ST_OUT && !out_stall);
        sctrl.insert = rd_v_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        radius_next  = radius_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_slot_next = in_slot_reg;
        col_next     = col_reg;
        end_next     = end_reg;
        orow_next    = orow_reg;
        oslot_next   = oslot_reg;
        ky_next      = ky_reg;
        kx_next      = kx_reg;
        rd_v_next    = gather;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    case (cfg_index)
                        REG_RADIUS: radius_next = cfg_data[1:0];
                        REG_WIDTH:  width_next  = cfg_data;
                        REG_HEIGHT: height_next = cfg_data;
                        default:    ;
                    endcase
                    if (cfg_index <= REG_HEIGHT)
                    begin
                        in_col_next  = '0;
                        in_row_next  = '0;
                        in_slot_next = '0;
                    end
                end
                else if (accept && !drop)
                begin
                    if (x1 >= w)
                    begin
                        in_col_next = '0;
                        if (y1 >= h + {9'd0, rad})
                        begin
                            in_row_next  = '0;
                            in_slot_next = '0;
                        end
                        else
                        begin
                            in_row_next  = y1;
                            in_slot_next = (in_slot_reg == 3'd4) ? 3'd0 : in_slot_reg + 3'd1;
                        end
                    end
                    else
                        in_col_next = x1[9:0];
                    if (emit)
                    begin
                        col_next   = start_c;
                        end_next   = end_c;
                        orow_next  = 10'(in_row_reg - {9'd0, rad});
                        oslot_next = os_tmp[2:0];
                        ky_next    = '0;
                        kx_next    = '0;
                        state_next = ST_GATHER;
                    end
                end
            end
            ST_GATHER:
            begin
                if (last_tap)
                    state_next = ST_SETTLE;
                else if (kx_reg == kmax)
                begin
                    kx_next = '0;
                    ky_next = ky_reg + 3'd1;
                end
                else
                    kx_next = kx_reg + 3'd1;
            end
            ST_SETTLE:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    if (col_reg == end_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        col_next   = col_reg + 10'd1;
                        ky_next    = '0;
                        kx_next    = '0;
                        state_next = ST_GATHER;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            radius_reg  <= 2'd1;
            width_reg   <= 11'(MAX_WIDTH);
            height_reg  <= 11'(MAX_HEIGHT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_slot_reg <= '0;
            rd_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            radius_reg  <= radius_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_slot_reg <= in_slot_next;
            rd_v_reg    <= rd_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        end_reg   <= end_next;
        orow_reg  <= orow_next;
        oslot_reg <= oslot_next;
        ky_reg    <= ky_next;
        kx_reg    <= kx_next;
    end

    // line store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[{in_slot_reg, in_col_reg}] <= pixel_value;
        if (gather)
            mem_q <= store[rd_addr];
    end

    mf2d_sorter u_sorter
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sctrl),
        .din    (mem_q),
        .big    (big),
        .median (median)
    );

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = (state_reg == ST_OUT);
    assign median_value = median;
    assign out_col      = col_reg;
    assign out_row      = orow_reg;
    assign last_of_run  = (col_reg == end_reg);
    assign frame_done   = ({1'b0, orow_reg} == h - 11'd1) && ({1'b0, col_reg} == w - 11'd1);

    `MF_ASSERT(a_out_blocks_in, !out_valid || in_stall)
    `MF_ASSERT(a_done_is_last, !(out_valid && frame_done) || last_of_run)
    `MF_ASSERT_NEXT(a_gather_feeds, state_reg == ST_GATHER, rd_v_reg)

endmodule

[rtl/mf2d_cell.sv]
// ----------------------------------------------------------------------------
// mf2d_cell
// one slot of the insertion sorter, ascending order towards higher cells
// ----------------------------------------------------------------------------
module mf2d_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  mf2d_pkg::sort_ctrl_t ctrl,
    input  logic [15:0]         din,
    input  mf2d_pkg::cell_t     left,
    output mf2d_pkg::cell_t     dout
);
    import mf2d_pkg::*;

    cell_t cell_reg;
    cell_t cell_next;
    logic  lt_self;
    logic  lt_left;

    // an empty neighbour counts as larger than any sample
    always_comb
    begin
        lt_self   = !cell_reg.valid || (din < cell_reg.value);
        lt_left   = !left.valid || (din < left.value);
        cell_next = cell_reg;
        if (ctrl.clear)
            cell_next.valid = 1'b0;
        else if (ctrl.insert && lt_self)
        begin
            if (lt_left)
                cell_next = left;
            else
            begin
                cell_next.valid = 1'b1;
                cell_next.value = din;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else
            cell_reg <= cell_next;
    end

    assign dout = cell_reg;

endmodule

[rtl/mf2d_sorter.sv]
// ----------------------------------------------------------------------------
// mf2d_sorter
// chain of sort cells, one sample inserted per cycle, median tap
// ----------------------------------------------------------------------------
module mf2d_sorter
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mf2d_pkg::sort_ctrl_t ctrl,
    input  logic [15:0]          din,
    input  logic                 big,
    output logic [15:0]          median
);
    import mf2d_pkg::*;

    cell_t cells [NUM_CELLS];
    cell_t lefts [NUM_CELLS];

    // the first cell sees a neighbour no larger than any sample
    assign lefts[0] = '{valid: 1'b1, value: 16'd0};

    genvar i;
    generate
        for (i = 0; i < NUM_CELLS; i++)
        begin : g_cell
            if (i > 0)
            begin : g_left
                assign lefts[i] = cells[i-1];
            end
            mf2d_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .din   (din),
                .left  (lefts[i]),
                .dout  (cells[i])
            );
        end
    endgenerate

    assign median = big ? cells[MED_IDX_5].value : cells[MED_IDX_3].value;

endmodule
